>>> src/segment_box_slab_test_assert.svh
// Assertion macros for the segment box slab test block.
// Depends on nothing; files that check their logic include it.
`ifndef SEGMENT_BOX_SLAB_TEST_ASSERT_SVH
`define SEGMENT_BOX_SLAB_TEST_ASSERT_SVH
`ifndef SYNTHESIS
`define SBST_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sbst assertion failed");
`define SBST_ASSERT(lbl, prop) `SBST_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define SBST_ASSERT_CLK(lbl, clk, rst_n, prop)
`define SBST_ASSERT(lbl, prop)
`endif
`endif

>>> src/sbst_pkg.sv
// Types shared by the segment box slab test block.
// Depends on nothing.
package sbst_pkg;
  typedef logic signed [32:0] coord_t;  // corner, direction
  typedef logic signed [33:0] num_t;    // slab numerator
  typedef logic        [32:0] den_t;    // slab denominator, |d|
  typedef logic signed [67:0] prod_t;   // cross product
  localparam int unsigned NStages = 6;
endpackage

>>> src/segment_box_slab_test.sv
// Segment versus axis-aligned rectangle hit test, six register stages.
// Throughput: one beat per cycle; an output stall freezes every stage.
// Reset: rst_ni asynchronous, active low, clears all stage valid bits.
// Depends on sbst_pkg and segment_box_slab_test_assert.svh.
`include "segment_box_slab_test_assert.svh"
module segment_box_slab_test
  import sbst_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] end_x_i,
  input  logic signed [31:0] end_y_i,
  input  logic signed [31:0] box_origin_x_i,
  input  logic signed [31:0] box_origin_y_i,
  input  logic signed [31:0] box_size_x_i,
  input  logic signed [31:0] box_size_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o
);

  logic [NStages:1] v_q;
  logic en;
  assign en = !v_q[NStages] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = v_q[NStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NStages-1:1], in_valid_i};
    end
  end

  // Stage 1: corners and direction
  coord_t lx_q, hx_q, ly_q, hy_q, dx_q, dy_q;
  coord_t sx_q, sy_q, ex_q, ey_q;
  coord_t ox, oy, fx, fy;
  always_comb begin
    ox = coord_t'(box_origin_x_i);
    oy = coord_t'(box_origin_y_i);
    fx = ox + coord_t'(box_size_x_i);
    fy = oy + coord_t'(box_size_y_i);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      lx_q <= (ox < fx) ? ox : fx;
      hx_q <= (ox < fx) ? fx : ox;
      ly_q <= (oy < fy) ? oy : fy;
      hy_q <= (oy < fy) ? fy : oy;
      sx_q <= coord_t'(start_x_i);
      sy_q <= coord_t'(start_y_i);
      ex_q <= coord_t'(end_x_i);
      ey_q <= coord_t'(end_y_i);
      dx_q <= coord_t'(end_x_i) - coord_t'(start_x_i);
      dy_q <= coord_t'(end_y_i) - coord_t'(start_y_i);
    end
  end

  // Stage 2: endpoint tests and slab numerators
  logic hit2_q, miss2_q;
  num_t enx2_q, lvx2_q, eny2_q, lvy2_q;
  den_t denx2_q, deny2_q;
  logic in_s, in_e, px, py;
  always_comb begin
    in_s = lx_q <= sx_q && ly_q <= sy_q && sx_q <= hx_q && sy_q <= hy_q;
    in_e = lx_q <= ex_q && ly_q <= ey_q && ex_q <= hx_q && ey_q <= hy_q;
    px   = !dx_q[32];
    py   = !dy_q[32];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit2_q  <= in_s || in_e;
      miss2_q <= dx_q == '0 || dy_q == '0;
      enx2_q  <= px ? num_t'(lx_q) - num_t'(sx_q) : num_t'(sx_q) - num_t'(hx_q);
      lvx2_q  <= px ? num_t'(hx_q) - num_t'(sx_q) : num_t'(sx_q) - num_t'(lx_q);
      eny2_q  <= py ? num_t'(ly_q) - num_t'(sy_q) : num_t'(sy_q) - num_t'(hy_q);
      lvy2_q  <= py ? num_t'(hy_q) - num_t'(sy_q) : num_t'(sy_q) - num_t'(ly_q);
      denx2_q <= px ? den_t'(dx_q) : den_t'(-dx_q);
      deny2_q <= py ? den_t'(dy_q) : den_t'(-dy_q);
    end
  end

  // Stage 3: cross products between the two slabs
  logic hit3_q, miss3_q;
  num_t enx3_q, lvx3_q, eny3_q, lvy3_q;
  den_t denx3_q, deny3_q;
  prod_t p_enx_q, p_eny_q, p_lvx_q, p_lvy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit3_q  <= hit2_q;
      miss3_q <= miss2_q;
      enx3_q  <= enx2_q;
      lvx3_q  <= lvx2_q;
      eny3_q  <= eny2_q;
      lvy3_q  <= lvy2_q;
      denx3_q <= denx2_q;
      deny3_q <= deny2_q;
      p_enx_q <= prod_t'(enx2_q * $signed({1'b0, deny2_q}));
      p_eny_q <= prod_t'(eny2_q * $signed({1'b0, denx2_q}));
      p_lvx_q <= prod_t'(lvx2_q * $signed({1'b0, deny2_q}));
      p_lvy_q <= prod_t'(lvy2_q * $signed({1'b0, denx2_q}));
    end
  end

  // Stage 4: pick latest entry and earliest exit
  logic hit4_q, miss4_q;
  num_t tmin4_q, tmax4_q;
  den_t dmin4_q, dmax4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit4_q  <= hit3_q;
      miss4_q <= miss3_q;
      tmin4_q <= (p_enx_q >= p_eny_q) ? enx3_q : eny3_q;
      dmin4_q <= (p_enx_q >= p_eny_q) ? denx3_q : deny3_q;
      tmax4_q <= (p_lvx_q <= p_lvy_q) ? lvx3_q : lvy3_q;
      dmax4_q <= (p_lvx_q <= p_lvy_q) ? denx3_q : deny3_q;
    end
  end

  // Stage 5: cross products of entry against exit
  logic hit5_q, miss5_q;
  num_t tmin5_q, tmax5_q;
  den_t dmin5_q, dmax5_q;
  prod_t q_min_q, q_max_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit5_q  <= hit4_q;
      miss5_q <= miss4_q;
      tmin5_q <= tmin4_q;
      tmax5_q <= tmax4_q;
      dmin5_q <= dmin4_q;
      dmax5_q <= dmax4_q;
      q_min_q <= prod_t'(tmin4_q * $signed({1'b0, dmax4_q}));
      q_max_q <= prod_t'(tmax4_q * $signed({1'b0, dmin4_q}));
    end
  end

  // Stage 6: reject, choose t, range check
  num_t t_num, t_den;
  logic reject, slab_hit;
  logic hit_q;
  always_comb begin
    reject   = tmax5_q[33] || (q_min_q > q_max_q);
    t_num    = tmin5_q[33] ? tmax5_q : tmin5_q;
    t_den    = tmin5_q[33] ? num_t'({1'b0, dmax5_q}) : num_t'({1'b0, dmin5_q});
    slab_hit = !miss5_q && !reject && (t_num > 0) && (t_num < t_den);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit5_q || slab_hit;
    end
  end
  assign hit_o = hit_q;

  `SBST_ASSERT(a_ready_rule, in_ready_o == (!out_valid_o || out_ready_i))
  `SBST_ASSERT(a_enter, (in_valid_i && in_ready_o) |=> v_q[1])
  `SBST_ASSERT(a_freeze, !en |=> $stable(v_q))
  `SBST_ASSERT_CLK(a_early_hit, clk_i, rst_ni, (en && v_q[5] && hit5_q) |=> hit_o)

endmodule

>>> bench/testbench.sv
// Self-checking bench for the segment versus rectangle hit test.
// Computes each expected hit flag with exact rational slab math; needs sbst_pkg
// and segment_box_slab_test.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sbst_pkg::*;

  typedef struct {
    logic signed [31:0] sx, sy, ex, ey, ox, oy, wx, wy;
  } query_t;

  typedef struct {
    logic signed [35:0] num;
    logic signed [35:0] den;
  } ratio_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] start_x_i = '0, start_y_i = '0, end_x_i = '0, end_y_i = '0;
  logic signed [31:0] box_origin_x_i = '0, box_origin_y_i = '0;
  logic signed [31:0] box_size_x_i = '0, box_size_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o;

  logic hit_queue[$];
  int unsigned mismatches = 0;
  longint unsigned cycle_count = 0;
  bit quiet_sink = 1'b0;

  segment_box_slab_test dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int ratio_cmp(ratio_t a, ratio_t b);
    logic signed [71:0] l, r;
    l = 72'(a.num) * 72'(b.den);
    r = 72'(b.num) * 72'(a.den);
    return (l < r) ? -1 : ((l > r) ? 1 : 0);
  endfunction

  function automatic logic predict_hit(query_t q);
    logic signed [35:0] sx, sy, ex, ey, ox, oy, fx, fy, lx, ly, hx, hy, dx, dy;
    ratio_t enx, lvx, eny, lvy, tmin, tmax, t;
    sx = q.sx; sy = q.sy; ex = q.ex; ey = q.ey; ox = q.ox; oy = q.oy;
    fx = ox + 36'(q.wx);
    fy = oy + 36'(q.wy);
    lx = (ox < fx) ? ox : fx; hx = (ox < fx) ? fx : ox;
    ly = (oy < fy) ? oy : fy; hy = (oy < fy) ? fy : oy;
    if ((lx <= sx && ly <= sy && sx <= hx && sy <= hy) ||
        (lx <= ex && ly <= ey && ex <= hx && ey <= hy))
      return 1'b1;
    dx = ex - sx;
    dy = ey - sy;
    if (dx == 0 || dy == 0) return 1'b0;
    if (dx > 0) begin
      enx = '{lx - sx, dx}; lvx = '{hx - sx, dx};
    end else begin
      enx = '{sx - hx, -dx}; lvx = '{sx - lx, -dx};
    end
    if (dy > 0) begin
      eny = '{ly - sy, dy}; lvy = '{hy - sy, dy};
    end else begin
      eny = '{sy - hy, -dy}; lvy = '{sy - ly, -dy};
    end
    tmin = (ratio_cmp(enx, eny) >= 0) ? enx : eny;
    tmax = (ratio_cmp(lvx, lvy) <= 0) ? lvx : lvy;
    if (tmax.num < 0 || ratio_cmp(tmin, tmax) > 0) return 1'b0;
    t = (tmin.num < 0) ? tmax : tmin;
    return (t.num > 0) && (t.num < t.den);
  endfunction

  // Gaps: mostly none or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_query(query_t q);
    int unsigned g;
    g = gap_len();
    // drop valid only when a gap follows, so back-to-back beats keep it high
    if (g != 0) in_valid_i <= 1'b0;
    repeat (g) @(posedge clk_i);
    in_valid_i <= 1'b1;
    start_x_i <= q.sx; start_y_i <= q.sy; end_x_i <= q.ex; end_y_i <= q.ey;
    box_origin_x_i <= q.ox; box_origin_y_i <= q.oy;
    box_size_x_i <= q.wx; box_size_y_i <= q.wy;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    hit_queue.push_back(predict_hit(q));
  endtask

  // Sink: random stalls, with quiet stretches of constant ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (hit_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat hit=%0b", hit_o);
        end else begin
          logic want;
          want = hit_queue.pop_front();
          if (hit_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("hit mismatch: expected %0b actual %0b", want, hit_o);
          end
        end
      end
      out_ready_i <= quiet_sink ? 1'b1 : ($urandom_range(0, 99) < 70);
    end
  end

  function automatic logic signed [31:0] rand_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
  endfunction

  task automatic test_directed();
    query_t q;
    // endpoint on an edge, inside, far corners, negative size
    q = '{0, 0, 32'sh10000, 32'sh10000, 0, 0, 32'sh20000, 32'sh20000}; send_query(q);
    q = '{-32'sh10000, 32'sh8000, -32'sh20000, 32'sh9000, 0, 0, 32'sh10000, 32'sh10000};
    send_query(q);
    q = '{32'sh30000, 32'sh30000, 32'sh40000, 32'sh40000, 32'sh20000, 32'sh20000,
          -32'sh20000, -32'sh20000}; send_query(q);
    // crossing diagonal, both endpoints outside
    q = '{-32'sh10000, -32'sh10000, 32'sh30000, 32'sh30000, 0, 0, 32'sh10000,
          32'sh10000}; send_query(q);
    q = '{32'sh30000, 32'sh30000, -32'sh10000, -32'sh10000, 0, 0, 32'sh10000,
          32'sh10000}; send_query(q);
    // axis-parallel crossing gives no hit
    q = '{-32'sh10000, 32'sh8000, 32'sh30000, 32'sh8000, 0, 0, 32'sh10000, 32'sh10000};
    send_query(q);
    q = '{32'sh8000, -32'sh10000, 32'sh8000, 32'sh30000, 0, 0, 32'sh10000, 32'sh10000};
    send_query(q);
    // zero length, outside and inside
    q = '{32'sh50000, 32'sh50000, 32'sh50000, 32'sh50000, 0, 0, 32'sh10000, 32'sh10000};
    send_query(q);
    q = '{32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000, 0, 0, 32'sh10000, 32'sh10000};
    send_query(q);
    // point box, pass-through and miss
    q = '{-32'sh10000, -32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 0, 0}; send_query(q);
    q = '{-32'sh10000, -32'sh10000, 32'sh10000, 32'sh20000, 0, 0, 0, 0}; send_query(q);
    // segment pointing away, and stopping short
    q = '{32'sh20000, 32'sh20000, 32'sh30000, 32'sh30000, 0, 0, 32'sh10000, 32'sh10000};
    send_query(q);
    q = '{-32'sh30000, -32'sh30000, -32'sh20000, -32'sh10000, 0, 0, 32'sh10000,
          32'sh10000}; send_query(q);
    // field extremes
    q = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
          32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}; send_query(q);
    q = '{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
          32'sh80000000, 32'sh80000000, 32'sh80000000}; send_query(q);
    q = '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0, 0,
          32'sh80000000, 32'sh7fffffff}; send_query(q);
    q = '{-1, -1, 1, 1, 0, 0, 32'sh7fffffff, 32'sh80000000}; send_query(q);
  endtask

  task automatic test_random_segments();
    query_t q;
    int unsigned r;
    for (int i = 0; i < 1000; i++) begin
      quiet_sink = (i >= 400 && i < 500);
      q.ox = rand_coord(); q.oy = rand_coord();
      q.wx = rand_coord(); q.wy = rand_coord();
      r = $urandom_range(0, 3);
      if (r == 0) begin
        q.sx = $urandom; q.sy = $urandom; q.ex = $urandom; q.ey = $urandom;
      end else begin
        // segments around the box so that slabs decide most beats
        q.sx = q.ox + ($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
        q.sy = q.oy + ($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
        q.ex = q.ox + ($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
        q.ey = q.oy + ($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
        if (r == 3) begin
          q.wx = $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
          q.wy = $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
        end
      end
      send_query(q);
    end
    quiet_sink = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_segments();
    in_valid_i <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk_i);
    repeat (NStages + 10) @(posedge clk_i);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

>>> sim.f
+incdir+src
src/sbst_pkg.sv
src/segment_box_slab_test.sv
bench/testbench.sv
